@@ hw/rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 stream converter.
package u8u16_pkg;

    typedef enum logic [3:0] {
        PH_FIRST   = 4'd0,
        PH_MARK1   = 4'd1,
        PH_MARK2   = 4'd2,
        PH_IDLE    = 4'd3,
        PH_TWO_1   = 4'd4,
        PH_THREE_1 = 4'd5,
        PH_THREE_2 = 4'd6,
        PH_FOUR_1  = 4'd7,
        PH_FOUR_2  = 4'd8,
        PH_FOUR_3  = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_MARK  = 3'd1,
        ERR_CONT  = 3'd2,
        ERR_RANGE = 3'd3,
        ERR_SURR  = 3'd4
    } t_err;

    typedef struct packed {
        logic [15:0] unit;
        t_err        err;
    } t_res;

    // Up to three code units caused by one input byte, entry 0 goes out first.
    typedef struct packed {
        logic [1:0]      cnt;
        t_res [2:0]      res;
    } t_batch;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRLF       = 2'd1;

    localparam logic [15:0] UNIT_BOM = 16'hFEFF;
    localparam logic [15:0] UNIT_CR  = 16'h000D;
    localparam logic [15:0] UNIT_LF  = 16'h000A;
    localparam logic [7:0]  BYTE_LF  = 8'h0A;
    localparam logic [7:0]  MARK_B0  = 8'hEF;
    localparam logic [7:0]  MARK_B1  = 8'hBB;
    localparam logic [7:0]  MARK_B2  = 8'hBF;

    localparam int OUT_TDATA_W = 24;

endpackage

@@ hw/rtl/u8u16_decode.sv @@
// Input register, decode state and per-byte code unit generation.
module u8u16_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tvalid,
    output logic                o_tready,
    input  logic [7:0]          i_tdata,
    input  logic                i_crlf,
    output logic                o_bat_vld,
    output u8u16_pkg::t_batch   o_bat,
    input  logic                i_bat_rdy
);

    logic                r_vld;
    logic [7:0]          r_byte;
    u8u16_pkg::t_phase   r_phase;
    u8u16_pkg::t_phase   n_phase;
    logic [20:0]         r_accum;
    logic [20:0]         n_accum;
    u8u16_pkg::t_batch   n_bat;
    logic                take;
    logic                cont;
    logic [20:0]         acc;
    logic [20:0]         cp;

    assign take     = r_vld && i_bat_rdy;
    assign o_tready = !r_vld || i_bat_rdy;
    assign o_bat_vld = r_vld;
    assign o_bat    = n_bat;

    assign cont = (r_byte[7:6] == 2'b10);
    assign acc  = {r_accum[14:0], r_byte[5:0]};
    assign cp   = acc - 21'h010000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= u8u16_pkg::PH_FIRST;
            r_accum <= '0;
        end else begin
            if (i_tvalid && o_tready) begin
                r_vld <= 1'b1;
            end else if (take) begin
                r_vld <= 1'b0;
            end
            if (take) begin
                r_phase <= n_phase;
                r_accum <= n_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_byte <= i_tdata;
        end
    end

    always_comb begin
        logic [1:0] k;
        logic       plain;
        k       = 2'd0;
        plain   = 1'b0;
        n_bat   = '0;
        n_phase = r_phase;
        n_accum = r_accum;
        case (r_phase)
            u8u16_pkg::PH_FIRST: begin
                n_bat.res[k] = '{unit: u8u16_pkg::UNIT_BOM, err: u8u16_pkg::ERR_NONE};
                k = k + 2'd1;
                if (r_byte == u8u16_pkg::MARK_B0) begin
                    n_phase = u8u16_pkg::PH_MARK1;
                end else begin
                    n_phase = u8u16_pkg::PH_IDLE;
                    plain   = 1'b1;
                end
            end
            u8u16_pkg::PH_MARK1: begin
                if (r_byte == u8u16_pkg::MARK_B1) begin
                    n_phase = u8u16_pkg::PH_MARK2;
                end else begin
                    n_phase = u8u16_pkg::PH_IDLE;
                    n_bat.res[k] = '{unit: 16'h0000, err: u8u16_pkg::ERR_MARK};
                    k = k + 2'd1;
                end
            end
            u8u16_pkg::PH_MARK2: begin
                n_phase = u8u16_pkg::PH_IDLE;
                if (r_byte != u8u16_pkg::MARK_B2) begin
                    n_bat.res[k] = '{unit: 16'h0000, err: u8u16_pkg::ERR_MARK};
                    k = k + 2'd1;
                end
            end
            u8u16_pkg::PH_IDLE: begin
                plain = 1'b1;
            end
            u8u16_pkg::PH_TWO_1, u8u16_pkg::PH_THREE_1, u8u16_pkg::PH_THREE_2,
            u8u16_pkg::PH_FOUR_1, u8u16_pkg::PH_FOUR_2, u8u16_pkg::PH_FOUR_3: begin
                if (!cont) begin
                    n_phase = u8u16_pkg::PH_IDLE;
                    n_bat.res[k] = '{unit: 16'h0000, err: u8u16_pkg::ERR_CONT};
                    k = k + 2'd1;
                end else begin
                    n_accum = acc;
                    case (r_phase)
                        u8u16_pkg::PH_THREE_1: n_phase = u8u16_pkg::PH_THREE_2;
                        u8u16_pkg::PH_FOUR_1:  n_phase = u8u16_pkg::PH_FOUR_2;
                        u8u16_pkg::PH_FOUR_2:  n_phase = u8u16_pkg::PH_FOUR_3;
                        default:               n_phase = u8u16_pkg::PH_IDLE;
                    endcase
                    if (r_phase == u8u16_pkg::PH_TWO_1) begin
                        if (acc >= 21'h80 && acc <= 21'h7FF) begin
                            n_bat.res[k] = '{unit: acc[15:0], err: u8u16_pkg::ERR_NONE};
                        end else begin
                            n_bat.res[k] = '{unit: 16'h0000, err: u8u16_pkg::ERR_RANGE};
                        end
                        k = k + 2'd1;
                    end else if (r_phase == u8u16_pkg::PH_THREE_2) begin
                        if (acc < 21'h800 || acc > 21'hFFFF) begin
                            n_bat.res[k] = '{unit: 16'h0000, err: u8u16_pkg::ERR_RANGE};
                        end else if (acc[15:11] == 5'b11011) begin
                            n_bat.res[k] = '{unit: 16'h0000, err: u8u16_pkg::ERR_SURR};
                        end else begin
                            n_bat.res[k] = '{unit: acc[15:0], err: u8u16_pkg::ERR_NONE};
                        end
                        k = k + 2'd1;
                    end else if (r_phase == u8u16_pkg::PH_FOUR_3) begin
                        if (acc >= 21'h10000 && acc <= 21'h10FFFF) begin
                            // split into high and low surrogate
                            n_bat.res[k] = '{unit: {6'b110110, cp[19:10]},
                                             err: u8u16_pkg::ERR_NONE};
                            k = k + 2'd1;
                            n_bat.res[k] = '{unit: {6'b110111, cp[9:0]},
                                             err: u8u16_pkg::ERR_NONE};
                        end else begin
                            n_bat.res[k] = '{unit: 16'h0000, err: u8u16_pkg::ERR_RANGE};
                        end
                        k = k + 2'd1;
                    end
                end
            end
            default: begin
                n_phase = u8u16_pkg::PH_IDLE;
            end
        endcase

        // plain byte handling while between sequences
        if (plain) begin
            if (r_byte == u8u16_pkg::BYTE_LF && i_crlf) begin
                n_bat.res[k] = '{unit: u8u16_pkg::UNIT_CR, err: u8u16_pkg::ERR_NONE};
                k = k + 2'd1;
                n_bat.res[k] = '{unit: u8u16_pkg::UNIT_LF, err: u8u16_pkg::ERR_NONE};
                k = k + 2'd1;
            end else if (!r_byte[7]) begin
                n_bat.res[k] = '{unit: {8'h00, r_byte}, err: u8u16_pkg::ERR_NONE};
                k = k + 2'd1;
            end else if (r_byte[7:5] == 3'b110) begin
                n_accum = {16'h0000, r_byte[4:0]};
                n_phase = u8u16_pkg::PH_TWO_1;
            end else if (r_byte[7:4] == 4'b1110) begin
                n_accum = {17'h00000, r_byte[3:0]};
                n_phase = u8u16_pkg::PH_THREE_1;
            end else if (r_byte[7:3] == 5'b11110) begin
                n_accum = {18'h00000, r_byte[2:0]};
                n_phase = u8u16_pkg::PH_FOUR_1;
            end
        end
        n_bat.cnt = k;
    end

`ifndef ASSERT_OFF
    a_three_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && n_bat.cnt == 2'd3) |-> (r_phase == u8u16_pkg::PH_FIRST))
        else $error("three results from a byte outside stream start");

    a_bad_cont_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !cont && r_phase >= u8u16_pkg::PH_TWO_1 &&
         r_phase <= u8u16_pkg::PH_FOUR_3) |=> (r_phase == u8u16_pkg::PH_IDLE))
        else $error("bad continuation did not restart decoding");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> ($stable(r_phase) && $stable(r_accum)))
        else $error("decode state moved without a consumed byte");
`endif

endmodule

@@ hw/rtl/u8u16_emit.sv @@
// Result buffer draining a byte's code units, one transfer per cycle if i_tready.
module u8u16_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_big_endian,
    input  logic                i_bat_vld,
    input  u8u16_pkg::t_batch   i_bat,
    output logic                o_bat_rdy,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [u8u16_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic                o_tlast
);

    u8u16_pkg::t_res [2:0] r_res;
    logic [1:0]            r_left;
    logic                  xfer;
    logic                  load;

    assign o_tvalid  = (r_left != 2'd0);
    assign xfer      = o_tvalid && i_tready;
    // refill once the last pending unit leaves
    assign o_bat_rdy = (r_left == 2'd0) || (r_left == 2'd1 && i_tready);
    assign load      = i_bat_vld && o_bat_rdy && (i_bat.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (load) begin
            r_left <= i_bat.cnt;
        end else if (xfer) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_bat.res;
        end else if (xfer) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_tlast = (r_left == 2'd1);
    assign o_tdata = {5'b00000, r_res[0].err,
                      i_big_endian ? r_res[0].unit[7:0]  : r_res[0].unit[15:8],
                      i_big_endian ? r_res[0].unit[15:8] : r_res[0].unit[7:0]};

`ifndef ASSERT_OFF
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_left == $past(i_bat.cnt)))
        else $error("pending count does not match loaded batch");

    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && r_res[0].err != u8u16_pkg::ERR_NONE) |->
        (o_tlast && r_res[0].unit == 16'h0000))
        else $error("error result not final or carries data");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !i_tready) |=> (r_left == $past(r_left)))
        else $error("pending units lost while stalled");
`endif

endmodule

@@ hw/rtl/utf8_to_utf16_stream_converter_unit.sv @@
// Top level of the UTF-8 to UTF-16 stream converter with its config registers.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata[7:0] in_byte
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata, tlast = last_of_run
//  cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// A byte is held in the input register, then its code units (zero to three)
// load the result buffer, which sends one unit per cycle while not stalled.
// Sustained rate is one byte per cycle for single-unit bytes; a byte with more
// units holds the next in the input register. Reset is synchronous, active low,
// and starts a new stream. Output stalls hold the buffer and the input register.
module utf8_to_utf16_stream_converter_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [7:0]                             i_s_axis_tdata,  // [7:0] in_byte
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // [7:0] first_byte, [15:8] second_byte, [18:16] error_code, [23:19] zero
    output logic [u8u16_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [u8u16_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic                                   i_cfg_data
);

    logic              r_big_endian;
    logic              r_crlf;
    logic              bat_vld;
    logic              bat_rdy;
    u8u16_pkg::t_batch bat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_crlf       <= 1'b0;
        end else if (i_cfg_valid) begin
            // ignore indexes past the register list
            case (i_cfg_index)
                u8u16_pkg::CFG_BIG_ENDIAN: r_big_endian <= i_cfg_data;
                u8u16_pkg::CFG_CRLF:       r_crlf       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    u8u16_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_crlf    (r_crlf),
        .o_bat_vld (bat_vld),
        .o_bat     (bat),
        .i_bat_rdy (bat_rdy)
    );

    u8u16_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_big_endian (r_big_endian),
        .i_bat_vld    (bat_vld),
        .i_bat        (bat),
        .o_bat_rdy    (bat_rdy),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata),
        .o_tlast      (o_m_axis_tlast)
    );

endmodule
